>>> sv/assert_macros.svh
// Assertion macros for RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define CHECK_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/utf8d_pkg.sv
package utf8d_pkg;

  localparam int unsigned CpWidth  = 31;
  localparam int unsigned LenWidth = 3;

  localparam logic [7:0] ContMask   = 8'b11000000;
  localparam logic [7:0] ContMark   = 8'b10000000;
  localparam logic [7:0] LeadMin    = 8'b11000000;
  localparam logic [7:0] LeadMax    = 8'b11111101;
  localparam logic [7:0] Lead3Min   = 8'b11100000;
  localparam logic [7:0] Lead4Min   = 8'b11110000;
  localparam logic [7:0] Lead5Min   = 8'b11111000;
  localparam logic [7:0] Lead6Min   = 8'b11111100;

  typedef struct packed {
    logic [CpWidth-1:0]  code_point;
    logic [LenWidth-1:0] seq_length;
    logic                error;
  } result_t;

  typedef struct packed {
    logic [CpWidth-1:0]  partial_value;
    logic [LenWidth-1:0] bytes_expected;
    logic [LenWidth-1:0] total_length;
  } dec_state_t;

endpackage

>>> sv/utf8d_step.sv
module utf8d_step (
  input  utf8d_pkg::dec_state_t state,
  input  logic [7:0]            data_byte,
  output utf8d_pkg::dec_state_t state_next,
  output logic                  emit,
  output utf8d_pkg::result_t    result
);
  import utf8d_pkg::*;

  logic is_cont;

  assign is_cont = (data_byte & ContMask) == ContMark;

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    result     = '0;
    if (state.bytes_expected != '0) begin
      if (!is_cont) begin
        state_next   = '0;
        emit         = 1'b1;
        result.error = 1'b1;
      end else if (state.bytes_expected == LenWidth'(1)) begin
        state_next        = '0;
        emit              = 1'b1;
        result.code_point = {state.partial_value[CpWidth-7:0], data_byte[5:0]};
        result.seq_length = state.total_length;
      end else begin
        state_next.partial_value  = {state.partial_value[CpWidth-7:0], data_byte[5:0]};
        state_next.bytes_expected = state.bytes_expected - LenWidth'(1);
      end
    end else begin
      priority if (data_byte[7] == 1'b0) begin
        emit              = 1'b1;
        result.code_point = CpWidth'(data_byte);
        result.seq_length = LenWidth'(1);
      end else if (data_byte < LeadMin || data_byte > LeadMax) begin
        emit         = 1'b1;
        result.error = 1'b1;
      end else if (data_byte >= Lead6Min) begin
        state_next.total_length   = LenWidth'(6);
        state_next.bytes_expected = LenWidth'(5);
        state_next.partial_value  = CpWidth'(data_byte[0]);
      end else if (data_byte >= Lead5Min) begin
        state_next.total_length   = LenWidth'(5);
        state_next.bytes_expected = LenWidth'(4);
        state_next.partial_value  = CpWidth'(data_byte[1:0]);
      end else if (data_byte >= Lead4Min) begin
        state_next.total_length   = LenWidth'(4);
        state_next.bytes_expected = LenWidth'(3);
        state_next.partial_value  = CpWidth'(data_byte[2:0]);
      end else if (data_byte >= Lead3Min) begin
        state_next.total_length   = LenWidth'(3);
        state_next.bytes_expected = LenWidth'(2);
        state_next.partial_value  = CpWidth'(data_byte[3:0]);
      end else begin
        state_next.total_length   = LenWidth'(2);
        state_next.bytes_expected = LenWidth'(1);
        state_next.partial_value  = CpWidth'(data_byte[4:0]);
      end
    end
  end

endmodule

>>> sv/utf8d_out_reg.sv
module utf8d_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  utf8d_pkg::result_t load_data,
  input  logic               out_stall,
  output logic               busy,
  output logic               out_valid,
  output utf8d_pkg::result_t out_data
);
  import utf8d_pkg::*;

  assign busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!busy) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && load) begin
      out_data <= load_data;
    end
  end

endmodule

>>> sv/utf8_stream_decoder_core.sv
// Byte-serial decoder for the original six-byte UTF-8 form.
// Input channel: in_valid, in_stall and data_byte carry one stream byte per
// transaction. Output channel: out_valid, out_stall, code_point, seq_length
// and error carry one result per transaction.
// A byte below 0x80 yields a one-byte result. A lead byte from 0xC0 to 0xFD
// yields nothing; the matching last continuation byte yields the code point
// and the sequence length. A stray continuation byte, 0xFE, 0xFF, or any
// non-continuation byte inside a sequence yields one result with error set
// and code_point and seq_length at zero, and the decoder returns to idle.
// A result is registered and appears in the cycle after the byte that
// completes it is accepted. Throughput is one byte per cycle while out_stall
// is low, set by the single decode step between state and output registers.
// When the receiver stalls a waiting result, in_stall rises in the same
// cycle and the result holds until taken; no byte is lost.
// Synchronous reset clears any partial sequence and the output valid flag.
`include "assert_macros.svh"

module utf8_stream_decoder_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      data_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [utf8d_pkg::CpWidth-1:0]   code_point,
  output logic [utf8d_pkg::LenWidth-1:0]  seq_length,
  output logic                            error
);
  import utf8d_pkg::*;

  dec_state_t state;
  dec_state_t state_next;
  logic       emit;
  result_t    step_result;
  result_t    out_data;
  logic       busy;
  logic       accept;

  utf8d_step u_step (
    .state      (state),
    .data_byte  (data_byte),
    .state_next (state_next),
    .emit       (emit),
    .result     (step_result)
  );

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  utf8d_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && emit),
    .load_data (step_result),
    .out_stall (out_stall),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign code_point = out_data.code_point;
  assign seq_length = out_data.seq_length;
  assign error      = out_data.error;

  `CHECK_CLK(a_err_clean, out_valid && error |-> code_point == '0 && seq_length == '0, "error result carries data")
  `CHECK_CLK(a_ascii_len, out_valid && !error && seq_length == LenWidth'(1) |-> code_point < CpWidth'(128), "one-byte result out of range")
  `CHECK_CLK(a_ok_len, out_valid && !error |-> seq_length != '0 && seq_length <= LenWidth'(6), "bad sequence length")
  `CHECK_ALWAYS(a_pending, state.bytes_expected != '0 |-> state.bytes_expected < state.total_length, "pending count exceeds length")
  `CHECK_ALWAYS(a_stall_src, in_stall |-> out_valid, "input stalled with empty output")

endmodule
